// ===== hw/rtl/mqtt_packet_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// MQTT packet deframer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, idle in reset.
// ---------------------------------------------------------------------------
`ifndef MQTT_PACKET_DEFRAMER_MACROS_SVH
`define MQTT_PACKET_DEFRAMER_MACROS_SVH

// Property must hold at every edge out of reset.
`define MPD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be seen out of reset.
`define MPD_ASSERT_NEVER(label, cond, msg) \
  `MPD_ASSERT(label, !(cond), msg)

`endif

// ===== hw/rtl/mpd_pkg.sv =====
// ---------------------------------------------------------------------------
// MQTT packet deframer package
// Beat types, result codes and framing constants shared by all modules.
// ---------------------------------------------------------------------------
package mpd_pkg;

  localparam int unsigned LenW = 28;

  // Input mode codes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOS  = 1'b1;

  // Variable byte integer layout
  localparam logic [7:0] LEN_VALUE_MASK = 8'h7F;
  localparam int unsigned LEN_CONT_BIT  = 7;

  localparam logic [LenW-1:0] LEN_MAX = 28'hFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_LEN_BYTES = 2'd1,
    ERR_TOO_LONG  = 2'd2,
    ERR_EOS       = 2'd3
  } err_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      first_byte;
    logic [LenW-1:0] body_length;
    logic [7:0]      body_byte;
    logic            last;
    err_e            error_code;
  } out_t;

endpackage

// ===== hw/rtl/mpd_front.sv =====
// ---------------------------------------------------------------------------
// MQTT deframer front end
// Takes input beats, decodes type byte and remaining length, tracks the
// body and pushes at most one result per beat into the queue.
// ---------------------------------------------------------------------------
`include "mqtt_packet_deframer_macros.svh"

module mpd_front #(
  parameter int unsigned MAX_LENGTH_BYTES = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mpd_pkg::LenW-1:0]  cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mpd_pkg::in_t              in_data_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output mpd_pkg::out_t             q_data_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DEAD = 2'd3
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [7:0]                type_q, type_d;
  logic [mpd_pkg::LenW-1:0]  acc_q, acc_d;
  logic [2:0]                lbc_q, lbc_d;
  logic [mpd_pkg::LenW-1:0]  rem_q, rem_d;
  logic [mpd_pkg::LenW-1:0]  max_q;

  logic                      accept;
  logic [6:0]                b7;
  logic [mpd_pkg::LenW-1:0]  len_add;
  logic [mpd_pkg::LenW-1:0]  acc_new;
  logic [2:0]                lbc_inc;

  // Dead state swallows beats; otherwise wait for queue room
  assign in_ready_o = (phase_q == PH_DEAD) || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Place the 7 value bits of this length byte
  assign b7 = in_data_i.data_in[6:0] & mpd_pkg::LEN_VALUE_MASK[6:0];
  always_comb begin
    unique case (lbc_q[1:0])
      2'd0:    len_add = {21'd0, b7};
      2'd1:    len_add = {14'd0, b7, 7'd0};
      2'd2:    len_add = {7'd0, b7, 14'd0};
      default: len_add = {b7, 21'd0};
    endcase
  end
  assign acc_new = acc_q | len_add;
  assign lbc_inc = lbc_q + 3'd1;

  // Framing decisions
  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    acc_d    = acc_q;
    lbc_d    = lbc_q;
    rem_d    = rem_q;
    q_push_o = 1'b0;
    q_data_o = '0;
    q_data_o.first_byte = type_q;
    q_data_o.body_length = acc_q;
    if (accept && phase_q != PH_DEAD) begin
      priority if (in_data_i.mode == mpd_pkg::MODE_EOS) begin
        phase_d  = PH_DEAD;
        q_push_o = 1'b1;
        q_data_o = '0;
        q_data_o.kind = mpd_pkg::KIND_ERROR;
        q_data_o.error_code = mpd_pkg::ERR_EOS;
      end else if (phase_q == PH_IDLE) begin
        type_d  = in_data_i.data_in;
        acc_d   = '0;
        lbc_d   = '0;
        rem_d   = '0;
        phase_d = PH_LEN;
      end else if (phase_q == PH_LEN) begin
        acc_d = acc_new;
        lbc_d = lbc_inc;
        priority if (in_data_i.data_in[mpd_pkg::LEN_CONT_BIT]) begin
          if (lbc_inc >= 3'(MAX_LENGTH_BYTES)) begin
            phase_d  = PH_DEAD;
            q_push_o = 1'b1;
            q_data_o = '0;
            q_data_o.kind = mpd_pkg::KIND_ERROR;
            q_data_o.error_code = mpd_pkg::ERR_LEN_BYTES;
          end
        end else if (acc_new > max_q) begin
          phase_d  = PH_DEAD;
          q_push_o = 1'b1;
          q_data_o = '0;
          q_data_o.kind = mpd_pkg::KIND_ERROR;
          q_data_o.error_code = mpd_pkg::ERR_TOO_LONG;
        end else begin
          q_push_o = 1'b1;
          q_data_o.kind = mpd_pkg::KIND_HEADER;
          q_data_o.body_length = acc_new;
          q_data_o.last = (acc_new == '0);
          rem_d   = acc_new;
          phase_d = (acc_new == '0) ? PH_IDLE : PH_BODY;
        end
      end else begin
        // Body byte
        q_push_o = 1'b1;
        q_data_o.kind = mpd_pkg::KIND_BODY;
        q_data_o.body_byte = in_data_i.data_in;
        if (rem_q <= mpd_pkg::LenW'(1)) begin
          q_data_o.last = 1'b1;
          rem_d   = '0;
          phase_d = PH_IDLE;
        end else begin
          rem_d = rem_q - mpd_pkg::LenW'(1);
        end
      end
    end
  end

  // State and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      type_q  <= '0;
      acc_q   <= '0;
      lbc_q   <= '0;
      rem_q   <= '0;
      max_q   <= mpd_pkg::LEN_MAX;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      acc_q   <= acc_d;
      lbc_q   <= lbc_d;
      rem_q   <= rem_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  `MPD_ASSERT(a_err_kills, (q_push_o && q_data_o.kind == mpd_pkg::KIND_ERROR) |=> (phase_q == PH_DEAD), "error result did not stop the parser")
  `MPD_ASSERT(a_dead_sticks, (phase_q == PH_DEAD) |=> (phase_q == PH_DEAD) && !q_push_o, "parser left dead state")

endmodule

// ===== hw/rtl/mpd_queue.sv =====
// ---------------------------------------------------------------------------
// MQTT deframer result queue
// Small register FIFO between the front end and the output stage.
// ---------------------------------------------------------------------------
`include "mqtt_packet_deframer_macros.svh"

module mpd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpd_pkg::out_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mpd_pkg::out_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mpd_pkg::out_t   mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  `MPD_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into full queue")
  `MPD_ASSERT(a_cnt_up, (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "count stuck")

endmodule

// ===== hw/rtl/mpd_back.sv =====
// ---------------------------------------------------------------------------
// MQTT deframer output stage
// Drains the queue, cleans up result fields per kind and holds the
// result in an output register until it is taken.
// ---------------------------------------------------------------------------
module mpd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mpd_pkg::out_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mpd_pkg::out_t out_data_o
);

  logic          out_valid_q;
  mpd_pkg::out_t out_q, fmt;
  logic          load;

  // Output register free or being drained this cycle
  assign load    = !out_valid_q || out_ready_i;
  assign q_pop_o = load && q_valid_i;

  // Per-kind field cleanup
  always_comb begin
    fmt = q_data_i;
    unique case (q_data_i.kind)
      mpd_pkg::KIND_ERROR: begin
        fmt = '0;
        fmt.kind = mpd_pkg::KIND_ERROR;
        fmt.error_code = q_data_i.error_code;
      end
      mpd_pkg::KIND_HEADER: begin
        fmt.body_byte  = '0;
        fmt.error_code = mpd_pkg::ERR_NONE;
      end
      mpd_pkg::KIND_BODY: begin
        fmt.error_code = mpd_pkg::ERR_NONE;
      end
      default: begin
        fmt = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= fmt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= q_valid_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/mqtt_packet_deframer.sv =====
// MQTT packet deframer: takes one byte (or end-of-stream event) per clock
// while the result queue has room, and gives one result per accepted beat
// that produces one, through the result queue and then the output register.
// Length decode and body count in the front end are combinational, so the
// sustained rate is one beat per clock when the output is taken. A small
// result queue and the output register let the input keep flowing while a
// result waits. After any error result the block keeps accepting and
// discarding input until reset. The user must write max_packet_size through
// cfg_we_i/cfg_wdata_i only while no beat is in flight; it is not enforced.
// ---------------------------------------------------------------------------
// MQTT packet deframer top level
// Front end, result queue and output stage.
// ---------------------------------------------------------------------------
module mqtt_packet_deframer #(
  parameter int unsigned MAX_LENGTH_BYTES = 4,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mpd_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mpd_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mpd_pkg::out_t            out_data_o
);

  logic          q_push, q_full, q_pop, q_valid;
  mpd_pkg::out_t q_wdata, q_rdata;

  mpd_front #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  mpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  mpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/mqtt_packet_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// MQTT packet deframer result checker
// Watches the config port and both beat channels, runs its own framing
// predictor on every accepted input beat and compares each accepted result
// beat, field by field, against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_packet_deframer_checker #(
  parameter int unsigned MaxLengthBytes = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mpd_pkg::LenW-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  mpd_pkg::in_t             in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  mpd_pkg::out_t            out_data_i,
  output int unsigned              pending_o,
  output int unsigned              fail_count_o
);

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_LENGTH,
    FR_BODY,
    FR_HALTED
  } frame_state_e;

  frame_state_e             frame_state;
  logic [7:0]               type_byte_q;
  logic [mpd_pkg::LenW-1:0] length_q;
  logic [mpd_pkg::LenW-1:0] remaining_q;
  logic [mpd_pkg::LenW-1:0] max_len_q;
  logic [2:0]               len_count_q;

  mpd_pkg::out_t expected_results [$];
  int unsigned   pending_q = 0;
  int unsigned   fail_q    = 0;

  assign pending_o    = pending_q;
  assign fail_count_o = fail_q;

  function automatic mpd_pkg::out_t make_result(mpd_pkg::kind_e k, logic [7:0] fb,
                                                logic [mpd_pkg::LenW-1:0] len,
                                                logic [7:0] bb, logic lst,
                                                mpd_pkg::err_e code);
    mpd_pkg::out_t r;
    r.kind        = k;
    r.first_byte  = fb;
    r.body_length = len;
    r.body_byte   = bb;
    r.last        = lst;
    r.error_code  = code;
    return r;
  endfunction

  // Any error kills the framer until reset
  task automatic raise_error(input mpd_pkg::err_e code);
    frame_state = FR_HALTED;
    expected_results.push_back(
      make_result(mpd_pkg::KIND_ERROR, 8'h00, '0, 8'h00, 1'b0, code));
  endtask

  // Framing predictor: one accepted input beat in, zero or one result out
  task automatic predict_beat(input mpd_pkg::in_t beat);
    logic [mpd_pkg::LenW-1:0] chunk;
    logic                     lst;
    if (frame_state == FR_HALTED) return;
    if (beat.mode == mpd_pkg::MODE_EOS) begin
      raise_error(mpd_pkg::ERR_EOS);
      return;
    end
    case (frame_state)
      FR_IDLE: begin
        type_byte_q = beat.data_in;
        length_q    = '0;
        len_count_q = '0;
        remaining_q = '0;
        frame_state = FR_LENGTH;
      end
      FR_LENGTH: begin
        // little-endian 7-bit groups, high bit continues
        chunk       = mpd_pkg::LenW'(beat.data_in & mpd_pkg::LEN_VALUE_MASK);
        chunk       = chunk << (7 * len_count_q);
        length_q    = length_q + chunk;
        len_count_q = len_count_q + 3'd1;
        if (beat.data_in[mpd_pkg::LEN_CONT_BIT]) begin
          if (len_count_q >= MaxLengthBytes) raise_error(mpd_pkg::ERR_LEN_BYTES);
        end else if (length_q > max_len_q) begin
          raise_error(mpd_pkg::ERR_TOO_LONG);
        end else if (length_q == '0) begin
          frame_state = FR_IDLE;
          expected_results.push_back(
            make_result(mpd_pkg::KIND_HEADER, type_byte_q, '0, 8'h00, 1'b1,
                        mpd_pkg::ERR_NONE));
        end else begin
          remaining_q = length_q;
          frame_state = FR_BODY;
          expected_results.push_back(
            make_result(mpd_pkg::KIND_HEADER, type_byte_q, length_q, 8'h00, 1'b0,
                        mpd_pkg::ERR_NONE));
        end
      end
      default: begin
        lst = (remaining_q <= 1);
        if (lst) begin
          remaining_q = '0;
          frame_state = FR_IDLE;
        end else begin
          remaining_q = remaining_q - 1'b1;
        end
        expected_results.push_back(
          make_result(mpd_pkg::KIND_BODY, type_byte_q, length_q, beat.data_in, lst,
                      mpd_pkg::ERR_NONE));
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [mpd_pkg::LenW-1:0] want,
                             input logic [mpd_pkg::LenW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_q++;
    end
  endtask

  task automatic check_result(input mpd_pkg::out_t got);
    mpd_pkg::out_t want;
    if (expected_results.size() == 0) begin
      $error("result beat with none expected: kind 0x%0h", got.kind);
      fail_q++;
      return;
    end
    want = expected_results.pop_front();
    check_field("kind",        want.kind,        got.kind);
    check_field("first_byte",  want.first_byte,  got.first_byte);
    check_field("body_length", want.body_length, got.body_length);
    check_field("body_byte",   want.body_byte,   got.body_byte);
    check_field("last",        want.last,        got.last);
    check_field("error_code",  want.error_code,  got.error_code);
  endtask

  // Sample both channels on the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_state = FR_IDLE;
      type_byte_q = '0;
      length_q    = '0;
      remaining_q = '0;
      len_count_q = '0;
      max_len_q   = mpd_pkg::LEN_MAX;
      expected_results.delete();
    end else begin
      if (cfg_we_i) max_len_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    pending_q = expected_results.size();
  end

endmodule

// ===== test/mqtt_packet_deframer_test.sv =====
// ----------------------------------------------------------------------------
// MQTT packet deframer testbench
// Feeds directed and random MQTT byte streams through several max length
// settings with bursty input and a stalling output, then ends the stream
// with one randomly chosen framing error and checks that later beats are
// dropped. Results are checked by the attached checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mqtt_packet_deframer_test;

  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned BeatsPerLimit = 240;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     cfg_we    = 1'b0;
  logic [mpd_pkg::LenW-1:0] cfg_wdata = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  mpd_pkg::in_t             in_data   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  mpd_pkg::out_t            out_data;

  int unsigned pending_results;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned ready_run   = 0;
  logic        ready_level = 1'b0;

  // Opening stream: empty bodies, extreme bytes, padded length encodings
  logic [7:0] opening_stream [$] = '{
    8'hE0, 8'h00,                             // empty body
    8'hFF, 8'h01, 8'hFF,                      // one body byte, all ones
    8'h00, 8'h02, 8'h00, 8'h80,               // zero type byte
    8'h32, 8'h81, 8'h80, 8'h80, 8'h00, 8'hAA, // four length bytes, value one
    8'h10, 8'h80, 8'h00,                      // padded zero length
    8'h82, 8'h03, 8'h7F, 8'h01, 8'h55
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mqtt_packet_deframer i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  mqtt_packet_deframer_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .pending_o    (pending_results),
    .fail_count_o (mismatches)
  );

  // Receiver: alternating ready runs and stalls, sometimes long ready runs
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_level = !ready_level;
      if (ready_level) begin
        ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                : $urandom_range(1, 12);
      end else begin
        ready_run = $urandom_range(1, 6);
      end
    end
    ready_run = ready_run - 1;
    out_ready <= ready_level;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("mqtt_packet_deframer: mismatch");
      $finish;
    end
  end

  // Sender bursts: random gap, then a burst of random length
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_beat(input logic mode, input logic [7:0] data);
    pace_sender();
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, data_in: data};
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  task automatic send_data(input logic [7:0] data);
    send_beat(mpd_pkg::MODE_DATA, data);
  endtask

  function automatic int min_length_bytes(input logic [mpd_pkg::LenW-1:0] value);
    int                       n;
    logic [mpd_pkg::LenW-1:0] rest;
    n    = 1;
    rest = value >> 7;
    while (rest != '0) begin
      n++;
      rest = rest >> 7;
    end
    return n;
  endfunction

  // Variable byte integer, padded out to nbytes with continuation bits
  task automatic send_length(input logic [mpd_pkg::LenW-1:0] value, input int nbytes);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = 8'(value >> (7 * i)) & mpd_pkg::LEN_VALUE_MASK;
      if (i < nbytes - 1) b[mpd_pkg::LEN_CONT_BIT] = 1'b1;
      send_data(b);
    end
  endtask

  task automatic send_random_packet(input int unsigned limit);
    int unsigned cap;
    int unsigned len;
    int          nb;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: cap = 12;
      10, 11, 12, 13:               cap = 64;
      default:                      cap = 300;
    endcase
    if (cap > limit) cap = limit;
    len = $urandom_range(0, cap);
    nb  = min_length_bytes(mpd_pkg::LenW'(len));
    if ($urandom_range(0, 3) == 0) nb = $urandom_range(nb, 4);
    send_data(8'($urandom_range(0, 255)));
    send_length(mpd_pkg::LenW'(len), nb);
    repeat (len) send_data(8'($urandom_range(0, 255)));
  endtask

  // Idle the input and wait until every predicted result is out
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_max_length(input logic [mpd_pkg::LenW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // The one terminating error; every beat after it must be dropped
  task automatic send_fatal_error();
    logic [mpd_pkg::LenW-1:0] limit;
    logic [mpd_pkg::LenW-1:0] len;
    mpd_pkg::err_e            code;
    code = mpd_pkg::err_e'($urandom_range(mpd_pkg::ERR_LEN_BYTES, mpd_pkg::ERR_EOS));
    case (code)
      mpd_pkg::ERR_LEN_BYTES: begin
        send_data(8'($urandom_range(0, 255)));
        repeat (4) send_data(8'h80 | 8'($urandom_range(0, 127)));
      end
      mpd_pkg::ERR_TOO_LONG: begin
        limit = mpd_pkg::LenW'($urandom_range(0, 1000));
        write_max_length(limit);
        case ($urandom_range(0, 2))
          0:       len = limit + 1'b1;
          1:       len = mpd_pkg::LEN_MAX;
          default: len = mpd_pkg::LenW'($urandom_range(limit + 1, mpd_pkg::LEN_MAX));
        endcase
        send_data(8'($urandom_range(0, 255)));
        send_length(len, $urandom_range(min_length_bytes(len), 4));
      end
      default: begin
        // end of stream between packets, after the type byte,
        // inside the length, or inside the body
        case ($urandom_range(0, 3))
          0: ;
          1: send_data(8'($urandom_range(0, 255)));
          2: begin
            send_data(8'($urandom_range(0, 255)));
            send_data(8'h80 | 8'($urandom_range(0, 127)));
          end
          default: begin
            send_data(8'($urandom_range(0, 255)));
            send_data(8'h05);
            repeat ($urandom_range(0, 4)) send_data(8'($urandom_range(0, 255)));
          end
        endcase
        send_beat(mpd_pkg::MODE_EOS, 8'($urandom_range(0, 255)));
      end
    endcase
    // dead: nothing more may come out
    send_beat(mpd_pkg::MODE_EOS, 8'($urandom_range(0, 255)));
    repeat (20) send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // Stimulus
  initial begin
    int unsigned limits [$];
    int unsigned phase_start;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset limit
    foreach (opening_stream[i]) send_data(opening_stream[i]);

    // random packets under several limits, extremes included
    limits.push_back(0);
    limits.push_back(1);
    limits.push_back($urandom_range(2, 40));
    limits.push_back(127);
    limits.push_back(128);
    limits.push_back(mpd_pkg::LEN_MAX);
    limits.push_back($urandom_range(200, 5000));
    foreach (limits[i]) begin
      drain();
      write_max_length(mpd_pkg::LenW'(limits[i]));
      phase_start = beats_sent;
      while (beats_sent - phase_start < BeatsPerLimit) send_random_packet(limits[i]);
    end

    drain();
    send_fatal_error();
    drain();

    if (mismatches == 0 && pending_results == 0) begin
      $display("mqtt_packet_deframer: match");
    end else begin
      $display("mqtt_packet_deframer: mismatch");
    end
    $finish;
  end

endmodule
